// ===== src/wfd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Shared widths, result kinds and register reset values.
// ----------------------------------------------------------------------------
package wfd_pkg;

	localparam int LENGTH_BITS_DEF = 24;

	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int OPCODE_W  = 4;
	localparam int FLEN_W    = 24;
	localparam int MAXLEN_W  = 24;
	localparam int TDATA_W   = 40;
	localparam int HCOUNT_W  = 3;

	localparam logic [MAXLEN_W-1:0] MAX_PAYLOAD_RESET = MAXLEN_W'(65536);

	localparam logic [6:0] LEN_ESC16 = 7'd126;
	localparam logic [6:0] LEN_ESC64 = 7'd127;

	localparam logic [HCOUNT_W-1:0] EXT16_COUNT = HCOUNT_W'(1);
	localparam logic [HCOUNT_W-1:0] EXT64_COUNT = HCOUNT_W'(7);
	localparam logic [HCOUNT_W-1:0] KEY_COUNT   = HCOUNT_W'(3);

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

endpackage

// ===== src/websocket_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame decoder
// Byte-serial frame header parser with payload unmasking and length check.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Content
// s_*       in   s_tvalid/s_tready  tdata[7:0] stream_byte
// m_*       out  m_tvalid/m_tready  tdata header/payload fields, tuser kind,
//                                   tlast end of frame
// cfg_*     in   cfg_valid/cfg_ready cfg_data[23:0] max_payload_bytes
//
// One byte per cycle while s_tready is high; a result is registered in the output
// register as its byte is taken, set by the single parse stage.
// Reset clears the parser to the first header byte and the limit to 65536.
// s_tready falls only while a result waits and m_tready is low.
// After an oversize error every byte is taken and dropped until reset.
// ----------------------------------------------------------------------------
module websocket_frame_decoder
	import wfd_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] stream_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // [0] final_fragment, [4:1] frame_opcode,
	                                        // [5] was_masked, [29:6] frame_length,
	                                        // [37:30] payload_value, [39:38] zero
	output logic [KIND_W-1:0]    m_tuser,   // [1:0] item_kind
	output logic                 m_tlast,   // end_of_frame
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MAXLEN_W-1:0]  cfg_data   // [23:0] max_payload_bytes
);

	localparam int CMP_W = (LENGTH_BITS > FLEN_W) ? LENGTH_BITS : FLEN_W;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_MASKKEY,
		PH_PAYLOAD,
		PH_ERROR
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [HCOUNT_W-1:0]      hcount_q, hcount_d;
	logic [LENGTH_BITS-1:0]   len_q, len_d;
	logic                     ovf_q, ovf_d;
	logic [31:0]              mask_q, mask_d;
	logic [1:0]               mpos_q, mpos_d;
	logic [LENGTH_BITS-1:0]   left_q, left_d;
	logic                     fin_q, fin_d;
	logic [OPCODE_W-1:0]      opc_q, opc_d;
	logic                     mflag_q, mflag_d;
	logic [MAXLEN_W-1:0]      max_q;

	logic                     res_vld;
	kind_t                    res_kind;
	logic [BYTE_W-1:0]        res_val;
	logic                     res_eof;
	logic                     len_done;
	logic                     hdr_done;
	logic                     oversize;
	logic [LENGTH_BITS+7:0]   len_shift;
	logic [CMP_W-1:0]         len_sat;
	logic [BYTE_W-1:0]        key_byte;

	logic                     m_tvalid_q;
	kind_t                    kind_q;
	logic                     ofin_q;
	logic [OPCODE_W-1:0]      oopc_q;
	logic                     omask_q;
	logic [FLEN_W-1:0]        olen_q;
	logic [BYTE_W-1:0]        oval_q;
	logic                     oeof_q;

	logic                     take;

	assign s_tready  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign take      = s_tvalid && s_tready;

	assign len_shift = {len_q, s_tdata};
	assign oversize  = ovf_d || (CMP_W'(len_d) > CMP_W'(max_q));
	assign len_sat   = ovf_d ? CMP_W'({LENGTH_BITS{1'b1}}) : CMP_W'(len_d);

	always_comb begin
		unique case (mpos_q)
			2'd0:    key_byte = mask_q[31:24];
			2'd1:    key_byte = mask_q[23:16];
			2'd2:    key_byte = mask_q[15:8];
			default: key_byte = mask_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		hcount_d = hcount_q;
		len_d    = len_q;
		ovf_d    = ovf_q;
		mask_d   = mask_q;
		mpos_d   = mpos_q;
		left_d   = left_q;
		fin_d    = fin_q;
		opc_d    = opc_q;
		mflag_d  = mflag_q;
		res_vld  = 1'b0;
		res_kind = KIND_PAYLOAD;
		res_val  = '0;
		res_eof  = 1'b0;
		len_done = 1'b0;
		hdr_done = 1'b0;

		unique case (phase_q)
			PH_SECOND: begin
				mflag_d = s_tdata[7];
				ovf_d   = 1'b0;
				if (s_tdata[6:0] == LEN_ESC16 || s_tdata[6:0] == LEN_ESC64) begin
					hcount_d = (s_tdata[6:0] == LEN_ESC16) ? EXT16_COUNT : EXT64_COUNT;
					len_d    = '0;
					phase_d  = PH_EXTLEN;
				end else begin
					len_d    = LENGTH_BITS'(s_tdata[6:0]);
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d = len_shift[LENGTH_BITS-1:0];
				ovf_d = ovf_q || (|len_shift[LENGTH_BITS+7:LENGTH_BITS]);
				if (hcount_q == '0) begin
					len_done = 1'b1;
				end else begin
					hcount_d = hcount_q - 1'b1;
				end
			end
			PH_MASKKEY: begin
				mask_d = {mask_q[23:0], s_tdata};
				if (hcount_q == '0) begin
					hdr_done = 1'b1;
				end else begin
					hcount_d = hcount_q - 1'b1;
				end
			end
			PH_PAYLOAD: begin
				res_vld  = 1'b1;
				res_kind = KIND_PAYLOAD;
				res_val  = mflag_q ? (s_tdata ^ key_byte) : s_tdata;
				mpos_d   = mpos_q + 1'b1;
				left_d   = left_q - 1'b1;
				res_eof  = (left_d == '0);
				if (res_eof) begin
					phase_d = PH_FIRST;
				end
			end
			PH_ERROR: begin
				phase_d = PH_ERROR;
			end
			default: begin
				fin_d    = s_tdata[7];
				opc_d    = s_tdata[OPCODE_W-1:0];
				mflag_d  = 1'b0;
				len_d    = '0;
				ovf_d    = 1'b0;
				hcount_d = '0;
				phase_d  = PH_SECOND;
			end
		endcase

		if (len_done) begin
			if (oversize) begin
				res_vld  = 1'b1;
				res_kind = KIND_ERROR;
				phase_d  = PH_ERROR;
			end else if (mflag_d) begin
				hcount_d = KEY_COUNT;
				mask_d   = '0;
				phase_d  = PH_MASKKEY;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			left_d   = len_d;
			mpos_d   = '0;
			res_vld  = 1'b1;
			res_kind = KIND_HEADER;
			res_eof  = (len_d == '0);
			phase_d  = (len_d == '0) ? PH_FIRST : PH_PAYLOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			hcount_q   <= '0;
			len_q      <= '0;
			ovf_q      <= 1'b0;
			mask_q     <= '0;
			mpos_q     <= '0;
			left_q     <= '0;
			fin_q      <= 1'b0;
			opc_q      <= '0;
			mflag_q    <= 1'b0;
			max_q      <= MAX_PAYLOAD_RESET;
			m_tvalid_q <= 1'b0;
			kind_q     <= KIND_PAYLOAD;
			ofin_q     <= 1'b0;
			oopc_q     <= '0;
			omask_q    <= 1'b0;
			olen_q     <= '0;
			oval_q     <= '0;
			oeof_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (take) begin
				phase_q  <= phase_d;
				hcount_q <= hcount_d;
				len_q    <= len_d;
				ovf_q    <= ovf_d;
				mask_q   <= mask_d;
				mpos_q   <= mpos_d;
				left_q   <= left_d;
				fin_q    <= fin_d;
				opc_q    <= opc_d;
				mflag_q  <= mflag_d;
			end
			if (s_tready) begin
				m_tvalid_q <= take && res_vld;
			end
			if (take && res_vld) begin
				kind_q  <= res_kind;
				ofin_q  <= fin_d;
				oopc_q  <= opc_d;
				omask_q <= mflag_d;
				olen_q  <= len_sat[FLEN_W-1:0];
				oval_q  <= res_val;
				oeof_q  <= res_eof;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = oeof_q;
	assign m_tdata  = {2'b00, oval_q, olen_q, omask_q, oopc_q, ofin_q};

`ifndef NO_ASSERTIONS
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tuser == KIND_ERROR) |=> !m_tvalid)
		else $error("result delivered after oversize error");

	a_error_no_eof: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tuser != KIND_ERROR))
		else $error("end of frame marked on error result");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (left_q != '0))
		else $error("payload phase with no bytes left");
`endif

endmodule
